@@ src/tspm_pkg.sv @@
`timescale 1ns / 1ps
package tspm_pkg;

   localparam int unsigned MAX_SUBJECTS_DEF = 64;
   localparam int unsigned MAX_VOXELS_DEF   = 1024;

   localparam int unsigned SMP_W  = 24;   // Q12.12 sample
   localparam int unsigned SUM_W  = 30;   // signed sum of up to 64 samples
   localparam int unsigned SQ_W   = 47;   // one squared sample
   localparam int unsigned QS_W   = 53;   // sum of squares
   localparam int unsigned N_W    = 7;    // subject counts
   localparam int unsigned K_W    = 10;   // (n1-1)*(n2-1)
   localparam int unsigned C_W    = 18;   // n*n*(n-1)
   localparam int unsigned D_W    = 60;   // n*Q - S*S
   localparam int unsigned A_W    = 38;   // S1*n2 - S2*n1, signed
   localparam int unsigned MAG_W  = 36;   // |A|
   localparam int unsigned MK_W   = 46;   // |A|*k
   localparam int unsigned MA_W   = 60;   // multiplier operand a
   localparam int unsigned MB_W   = 36;   // multiplier operand b
   localparam int unsigned MP_W   = MA_W + MB_W;
   localparam int unsigned E_W    = 77;   // variance denominator
   localparam int unsigned X_W    = 114;  // A*A*k << 32
   localparam int unsigned Q_W    = 62;   // quotient bits
   localparam int unsigned R_W    = 31;   // root bits
   localparam int unsigned T_W    = 32;   // Q16.16 result

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 11;
   localparam int unsigned VC_W       = 11;
   localparam int unsigned G1_W       = 6;

   localparam logic [N_W-1:0]  SUBJECT_COUNT_RST = 7'd64;
   localparam logic [G1_W-1:0] GROUP1_SIZE_RST   = 6'd32;
   localparam logic [VC_W-1:0] VOXEL_COUNT_RST   = 11'd1024;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SUBJECT_COUNT = 2'd0,
      REG_GROUP1_SIZE   = 2'd1,
      REG_VOXEL_COUNT   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COEF1,
      ST_COEF2,
      ST_READ,
      ST_DRAIN,
      ST_PROD,
      ST_DIFF,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_NEXT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MS_E1,
      MS_E2,
      MS_X
   } mul_step_type;

   typedef enum logic [1:0] {
      DS_IDLE,
      DS_DIV,
      DS_SQRT,
      DS_DONE
   } ds_state_type;

   typedef struct packed {
      logic rd_en;
      logic acc_clr;
      logic mul_start;
      logic ds_start;
      logic rsp_load;
   } ctl_type;

endpackage

@@ src/tspm_mul.sv @@
`timescale 1ns / 1ps
module tspm_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tspm_pkg::MA_W-1:0]   op_a,
   input  logic [tspm_pkg::MB_W-1:0]   op_b,
   output logic                        busy,
   output logic                        done,
   output logic [tspm_pkg::MP_W-1:0]   prod
);

   logic                      busy_ff;
   logic                      done_ff;
   logic [tspm_pkg::MP_W-1:0] acc_ff;
   logic [tspm_pkg::MP_W-1:0] a_sh_ff;
   logic [tspm_pkg::MB_W-1:0] b_sh_ff;
   logic                      last_step;

   // one bit of b per cycle, stop once the remaining bits are zero
   assign last_step = (b_sh_ff[tspm_pkg::MB_W-1:1] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= '0;
         a_sh_ff <= tspm_pkg::MP_W'(op_a);
         b_sh_ff <= op_b;
      end else if (busy_ff) begin
         if (b_sh_ff[0]) begin
            acc_ff <= acc_ff + a_sh_ff;
         end
         a_sh_ff <= {a_sh_ff[tspm_pkg::MP_W-2:0], 1'b0};
         b_sh_ff <= {1'b0, b_sh_ff[tspm_pkg::MB_W-1:1]};
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign prod = acc_ff;

endmodule

@@ src/tspm_divsqrt.sv @@
`timescale 1ns / 1ps
module tspm_divsqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tspm_pkg::X_W-1:0]   num,
   input  logic [tspm_pkg::E_W-1:0]   den,
   output logic                       done,
   output logic                       sat,
   output logic [tspm_pkg::R_W-1:0]   root
);

   localparam int unsigned TOP_W = tspm_pkg::X_W - tspm_pkg::Q_W;
   localparam int unsigned CNT_W = $clog2(tspm_pkg::Q_W);

   tspm_pkg::ds_state_type state_ff, state_in;

   logic [tspm_pkg::E_W-1:0]   rem_ff;
   logic [tspm_pkg::Q_W-1:0]   xlo_ff;
   logic [tspm_pkg::Q_W-1:0]   q_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       sat_ff;
   logic [tspm_pkg::Q_W-1:0]   v_ff;
   logic [tspm_pkg::Q_W-1:0]   res_ff;
   logic [tspm_pkg::Q_W-1:0]   bit_ff;

   logic [TOP_W-1:0]           top;
   logic                       sat_det;
   logic [tspm_pkg::E_W:0]     rem2;
   logic                       ge;
   logic                       last_div;
   logic [tspm_pkg::Q_W-1:0]   sum;

   assign top      = num[tspm_pkg::X_W-1:tspm_pkg::Q_W];
   assign sat_det  = (tspm_pkg::E_W'(top) >= den);
   assign rem2     = {rem_ff, xlo_ff[tspm_pkg::Q_W-1]};
   assign ge       = (rem2 >= {1'b0, den});
   assign last_div = (cnt_ff == CNT_W'(tspm_pkg::Q_W - 1));
   assign sum      = res_ff + bit_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tspm_pkg::DS_IDLE: begin
            if (start) state_in = sat_det ? tspm_pkg::DS_DONE : tspm_pkg::DS_DIV;
         end
         tspm_pkg::DS_DIV: begin
            if (last_div) state_in = tspm_pkg::DS_SQRT;
         end
         tspm_pkg::DS_SQRT: begin
            if (bit_ff[0]) state_in = tspm_pkg::DS_DONE;
         end
         tspm_pkg::DS_DONE: state_in = tspm_pkg::DS_IDLE;
         default: state_in = tspm_pkg::DS_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == tspm_pkg::DS_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tspm_pkg::DS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         tspm_pkg::DS_IDLE: begin
            if (start) begin
               sat_ff <= sat_det;
               rem_ff <= tspm_pkg::E_W'(top);
               xlo_ff <= num[tspm_pkg::Q_W-1:0];
               cnt_ff <= '0;
               q_ff   <= '0;
            end
         end
         tspm_pkg::DS_DIV: begin
            rem_ff <= ge ? tspm_pkg::E_W'(rem2 - {1'b0, den}) : rem2[tspm_pkg::E_W-1:0];
            q_ff   <= {q_ff[tspm_pkg::Q_W-2:0], ge};
            xlo_ff <= {xlo_ff[tspm_pkg::Q_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (last_div) begin
               v_ff   <= {q_ff[tspm_pkg::Q_W-2:0], ge};
               res_ff <= '0;
               bit_ff <= tspm_pkg::Q_W'(1) << (tspm_pkg::Q_W - 2);
            end
         end
         tspm_pkg::DS_SQRT: begin
            if (v_ff >= sum) begin
               v_ff   <= v_ff - sum;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         tspm_pkg::DS_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign sat  = sat_ff;
   assign root = res_ff[tspm_pkg::R_W-1:0];

endmodule

@@ src/two_sample_perm_max_t_core.sv @@
`timescale 1ns / 1ps
// Channel  Dir  tdata / tuser
// req_     in   tdata: subject_index, voxel_index, sample_value, membership_mask / tuser: kind
// rsp_     out  tdata: max_t_value / tuser: degenerate_seen
// csr_     in   write enable, register index, write data
//
// A load transaction writes one entry of the sample memory.
// A permutation walks the voxels from acceptance to result: per voxel N memory reads
// through the single read port, then passes through the shift-add multiplier
// and the divide and root unit, plus handshakes between the steps.
// Reset is synchronous; the sample memory is not cleared and holds garbage until loaded.
// The result sits in an output register; a new transaction is taken while it waits.
module two_sample_perm_max_t_core #(
   parameter int unsigned MAX_SUBJECTS = tspm_pkg::MAX_SUBJECTS_DEF,
   parameter int unsigned MAX_VOXELS   = tspm_pkg::MAX_VOXELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [5:0] subject_index, [15:6] voxel_index, [39:16] sample_value, [103:40] membership_mask
   input  logic [103:0]                       req_tdata,
   // [0] kind
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] max_t_value
   output logic [31:0]                        rsp_tdata,
   // [0] degenerate_seen
   output logic [0:0]                         rsp_tuser,
   input  logic                               csr_we,
   input  logic [tspm_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [tspm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned DEPTH = MAX_SUBJECTS * MAX_VOXELS;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned SW    = $clog2(MAX_SUBJECTS);
   localparam int unsigned VW    = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
   localparam int unsigned VCW   = $clog2(MAX_VOXELS + 1);
   localparam int unsigned NW    = tspm_pkg::N_W;

   // fields
   logic [5:0]                          req_subject;
   logic [9:0]                          req_voxel;
   logic signed [tspm_pkg::SMP_W-1:0]   req_sample;
   logic [63:0]                         req_mask;
   logic                                req_kind;

   assign req_subject = req_tdata[5:0];
   assign req_voxel   = req_tdata[15:6];
   assign req_sample  = req_tdata[39:16];
   assign req_mask    = req_tdata[103:40];
   assign req_kind    = req_tuser[0];

   // configuration
   logic [NW-1:0]                 subject_count_ff;
   logic [tspm_pkg::G1_W-1:0]     group1_size_ff;
   logic [tspm_pkg::VC_W-1:0]     voxel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         subject_count_ff <= tspm_pkg::SUBJECT_COUNT_RST;
         group1_size_ff   <= tspm_pkg::GROUP1_SIZE_RST;
         voxel_count_ff   <= tspm_pkg::VOXEL_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            tspm_pkg::REG_SUBJECT_COUNT: subject_count_ff <= NW'(csr_wdata);
            tspm_pkg::REG_GROUP1_SIZE:   group1_size_ff   <= tspm_pkg::G1_W'(csr_wdata);
            tspm_pkg::REG_VOXEL_COUNT:   voxel_count_ff   <= tspm_pkg::VC_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // clamped counts
   logic [NW-1:0]  n_c, n1_c, g1_ext;
   logic [VCW-1:0] nv_c;

   always_comb begin
      priority if (subject_count_ff < NW'(4))                      n_c = NW'(4);
      else if (32'(subject_count_ff) > 32'(MAX_SUBJECTS))          n_c = NW'(MAX_SUBJECTS);
      else                                                         n_c = subject_count_ff;
      g1_ext = NW'(group1_size_ff);
      priority if (g1_ext < NW'(2))                                n1_c = NW'(2);
      else if (g1_ext > n_c - NW'(2))                              n1_c = n_c - NW'(2);
      else                                                         n1_c = g1_ext;
      priority if (voxel_count_ff == '0)                           nv_c = VCW'(1);
      else if (32'(voxel_count_ff) > 32'(MAX_VOXELS))              nv_c = VCW'(MAX_VOXELS);
      else                                                         nv_c = VCW'(voxel_count_ff);
   end

   // control
   tspm_pkg::state_type    state_ff, state_in;
   tspm_pkg::mul_step_type step_ff;
   tspm_pkg::ctl_type      ctl;

   logic accept, acc_perm, acc_load;
   assign req_tready = (state_ff == tspm_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign acc_perm   = accept && req_kind;
   assign acc_load   = accept && !req_kind;

   logic [NW-1:0]  n_ff, n1_ff, n2_ff;
   logic [VCW-1:0] nv_ff;
   logic [63:0]    mask_ff;
   logic [SW-1:0]  sub_ff;
   logic [VW-1:0]  vox_ff;
   logic           last_sub, last_vox;

   assign last_sub = (NW'(sub_ff) == n_ff - NW'(1));
   assign last_vox = (VCW'(vox_ff) == nv_ff - VCW'(1));

   // accumulation pipeline
   logic                                 vld1_ff, vld2_ff, grp1_ff, grp2_ff;
   logic signed [tspm_pkg::SMP_W-1:0]    mem_q_ff, val2_ff;
   logic [tspm_pkg::SQ_W-1:0]            sq2_ff;
   logic signed [2*tspm_pkg::SMP_W-1:0]  sq_prod;
   logic signed [tspm_pkg::SUM_W-1:0]    s1_ff, s2_ff;
   logic [tspm_pkg::QS_W-1:0]            q1_ff, q2_ff;

   // memory
   logic signed [tspm_pkg::SMP_W-1:0] mem [DEPTH];
   logic [AW-1:0] waddr, raddr;
   logic          wr_en;

   assign wr_en = acc_load && (32'(req_subject) < 32'(MAX_SUBJECTS))
                           && (32'(req_voxel) < 32'(MAX_VOXELS));
   assign waddr = AW'(req_subject) * AW'(MAX_VOXELS) + AW'(req_voxel);
   assign raddr = AW'(sub_ff) * AW'(MAX_VOXELS) + AW'(vox_ff);

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= req_sample;
      if (ctl.rd_en) mem_q_ff <= mem[raddr];
   end

   assign sq_prod = mem_q_ff * mem_q_ff;

   // per-voxel arithmetic
   logic [2*NW-1:0]                   sq1_ff, sq2n_ff;
   logic [tspm_pkg::K_W-1:0]          k_ff;
   logic [tspm_pkg::C_W-1:0]          c1_ff, c2_ff;
   logic [tspm_pkg::D_W-1:0]          pa_ff, pb_ff, pc_ff, pd_ff, d1_ff, d2_ff;
   logic signed [tspm_pkg::A_W-1:0]   pe_ff, pf_ff, a_diff;
   logic [tspm_pkg::MAG_W-1:0]        mag_ff;
   logic                              neg_ff;
   logic [tspm_pkg::MK_W-1:0]         mk_ff;
   logic [tspm_pkg::E_W-1:0]          e_ff, e_sum;
   logic [tspm_pkg::X_W-1:0]          x_ff;
   logic signed [tspm_pkg::T_W-1:0]   best_ff, t_val;
   logic                              degen_ff;

   logic signed [tspm_pkg::D_W-1:0]   s1sq, s2sq;
   logic signed [tspm_pkg::A_W-1:0]   s1n2, s2n1;

   assign s1sq   = s1_ff * s1_ff;
   assign s2sq   = s2_ff * s2_ff;
   assign s1n2   = s1_ff * $signed({1'b0, n2_ff});
   assign s2n1   = s2_ff * $signed({1'b0, n1_ff});
   assign a_diff = pe_ff - pf_ff;

   // shared units
   logic [tspm_pkg::MA_W-1:0] mul_a;
   logic [tspm_pkg::MB_W-1:0] mul_b;
   logic                      mul_busy, mul_done;
   logic [tspm_pkg::MP_W-1:0] mul_p;
   logic                      ds_done, ds_sat;
   logic [tspm_pkg::R_W-1:0]  ds_root;

   assign e_sum = e_ff + tspm_pkg::E_W'(mul_p);

   always_comb begin
      unique case (step_ff)
         tspm_pkg::MS_E1: begin
            mul_a = d1_ff;
            mul_b = tspm_pkg::MB_W'(c1_ff);
         end
         tspm_pkg::MS_E2: begin
            mul_a = d2_ff;
            mul_b = tspm_pkg::MB_W'(c2_ff);
         end
         default: begin
            mul_a = tspm_pkg::MA_W'(mk_ff);
            mul_b = mag_ff;
         end
      endcase
   end

   tspm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (ctl.mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .busy  (mul_busy),
      .done  (mul_done),
      .prod  (mul_p)
   );

   tspm_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .start (ctl.ds_start),
      .num   (x_ff),
      .den   (e_ff),
      .done  (ds_done),
      .sat   (ds_sat),
      .root  (ds_root)
   );

   always_comb begin
      priority if (ds_sat)  t_val = neg_ff ? $signed({1'b1, {(tspm_pkg::T_W-1){1'b0}}})
                                           : $signed({1'b0, {(tspm_pkg::T_W-1){1'b1}}});
      else if (neg_ff)      t_val = -$signed({1'b0, ds_root});
      else                  t_val = $signed({1'b0, ds_root});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tspm_pkg::ST_IDLE:     if (acc_perm) state_in = tspm_pkg::ST_COEF1;
         tspm_pkg::ST_COEF1:    state_in = tspm_pkg::ST_COEF2;
         tspm_pkg::ST_COEF2:    state_in = tspm_pkg::ST_READ;
         tspm_pkg::ST_READ:     if (last_sub) state_in = tspm_pkg::ST_DRAIN;
         tspm_pkg::ST_DRAIN:    if (!vld1_ff && !vld2_ff) state_in = tspm_pkg::ST_PROD;
         tspm_pkg::ST_PROD:     state_in = tspm_pkg::ST_DIFF;
         tspm_pkg::ST_DIFF:     state_in = tspm_pkg::ST_MUL_GO;
         tspm_pkg::ST_MUL_GO:   state_in = tspm_pkg::ST_MUL_WAIT;
         tspm_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               unique case (step_ff)
                  tspm_pkg::MS_E1: state_in = tspm_pkg::ST_MUL_GO;
                  tspm_pkg::MS_E2: state_in = (e_sum == '0) ? tspm_pkg::ST_NEXT
                                                            : tspm_pkg::ST_MUL_GO;
                  default:         state_in = tspm_pkg::ST_DIV_GO;
               endcase
            end
         end
         tspm_pkg::ST_DIV_GO:   state_in = tspm_pkg::ST_DIV_WAIT;
         tspm_pkg::ST_DIV_WAIT: if (ds_done) state_in = tspm_pkg::ST_NEXT;
         tspm_pkg::ST_NEXT:     state_in = last_vox ? tspm_pkg::ST_OUT : tspm_pkg::ST_READ;
         tspm_pkg::ST_OUT:      if (!rsp_tvalid || rsp_tready) state_in = tspm_pkg::ST_IDLE;
         default:               state_in = tspm_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      ctl           = '0;
      ctl.rd_en     = (state_ff == tspm_pkg::ST_READ);
      ctl.acc_clr   = (state_ff == tspm_pkg::ST_COEF1) || (state_ff == tspm_pkg::ST_NEXT);
      ctl.mul_start = (state_ff == tspm_pkg::ST_MUL_GO);
      ctl.ds_start  = (state_ff == tspm_pkg::ST_DIV_GO);
      ctl.rsp_load  = (state_ff == tspm_pkg::ST_OUT) && (!rsp_tvalid || rsp_tready);
   end

   logic                            rsp_tvalid_ff;
   logic [tspm_pkg::T_W-1:0]        rsp_data_ff;
   logic                            rsp_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tspm_pkg::ST_IDLE;
         vld1_ff       <= 1'b0;
         vld2_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld1_ff  <= ctl.rd_en;
         vld2_ff  <= vld1_ff;
         if (ctl.rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      grp1_ff <= mask_ff[6'(sub_ff)];
      grp2_ff <= grp1_ff;
      val2_ff <= mem_q_ff;
      sq2_ff  <= tspm_pkg::SQ_W'(sq_prod);

      if (ctl.acc_clr) begin
         s1_ff <= '0;
         s2_ff <= '0;
         q1_ff <= '0;
         q2_ff <= '0;
      end else if (vld2_ff) begin
         if (grp2_ff) begin
            s1_ff <= s1_ff + tspm_pkg::SUM_W'(val2_ff);
            q1_ff <= q1_ff + tspm_pkg::QS_W'(sq2_ff);
         end else begin
            s2_ff <= s2_ff + tspm_pkg::SUM_W'(val2_ff);
            q2_ff <= q2_ff + tspm_pkg::QS_W'(sq2_ff);
         end
      end

      if (ctl.rsp_load) begin
         rsp_data_ff  <= best_ff;
         rsp_degen_ff <= degen_ff;
      end

      unique case (state_ff)
         tspm_pkg::ST_IDLE: begin
            if (acc_perm) begin
               n_ff     <= n_c;
               n1_ff    <= n1_c;
               n2_ff    <= n_c - n1_c;
               nv_ff    <= nv_c;
               mask_ff  <= req_mask;
               sub_ff   <= '0;
               vox_ff   <= '0;
               best_ff  <= $signed({1'b1, {(tspm_pkg::T_W-1){1'b0}}});
               degen_ff <= 1'b0;
            end
         end
         tspm_pkg::ST_COEF1: begin
            sq1_ff  <= n1_ff * n1_ff;
            sq2n_ff <= n2_ff * n2_ff;
            k_ff    <= tspm_pkg::K_W'((n1_ff - NW'(1)) * (n2_ff - NW'(1)));
         end
         tspm_pkg::ST_COEF2: begin
            c1_ff <= tspm_pkg::C_W'(sq2n_ff * (n2_ff - NW'(1)));
            c2_ff <= tspm_pkg::C_W'(sq1_ff * (n1_ff - NW'(1)));
         end
         tspm_pkg::ST_READ: begin
            sub_ff <= sub_ff + 1'b1;
         end
         tspm_pkg::ST_DRAIN: begin
         end
         tspm_pkg::ST_PROD: begin
            pa_ff <= tspm_pkg::D_W'(n1_ff) * tspm_pkg::D_W'(q1_ff);
            pb_ff <= $unsigned(s1sq);
            pc_ff <= tspm_pkg::D_W'(n2_ff) * tspm_pkg::D_W'(q2_ff);
            pd_ff <= $unsigned(s2sq);
            pe_ff <= s1n2;
            pf_ff <= s2n1;
         end
         tspm_pkg::ST_DIFF: begin
            // clamp negative spreads to zero
            d1_ff   <= (pa_ff >= pb_ff) ? pa_ff - pb_ff : '0;
            d2_ff   <= (pc_ff >= pd_ff) ? pc_ff - pd_ff : '0;
            neg_ff  <= a_diff[tspm_pkg::A_W-1];
            mag_ff  <= tspm_pkg::MAG_W'(a_diff[tspm_pkg::A_W-1] ? -a_diff : a_diff);
            step_ff <= tspm_pkg::MS_E1;
         end
         tspm_pkg::ST_MUL_GO: begin
            if (step_ff == tspm_pkg::MS_E1) begin
               mk_ff <= tspm_pkg::MK_W'(mag_ff * tspm_pkg::MAG_W'(k_ff));
            end
         end
         tspm_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               unique case (step_ff)
                  tspm_pkg::MS_E1: begin
                     e_ff    <= tspm_pkg::E_W'(mul_p);
                     step_ff <= tspm_pkg::MS_E2;
                  end
                  tspm_pkg::MS_E2: begin
                     e_ff    <= e_sum;
                     step_ff <= tspm_pkg::MS_X;
                     if (e_sum == '0) degen_ff <= 1'b1;
                  end
                  default: begin
                     x_ff <= {mul_p[tspm_pkg::X_W-33:0], 32'd0};
                  end
               endcase
            end
         end
         tspm_pkg::ST_DIV_GO: begin
         end
         tspm_pkg::ST_DIV_WAIT: begin
            if (ds_done && (t_val > best_ff)) best_ff <= t_val;
         end
         tspm_pkg::ST_NEXT: begin
            sub_ff <= '0;
            vox_ff <= vox_ff + 1'b1;
         end
         tspm_pkg::ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_degen_ff;

   // checks
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == tspm_pkg::ST_OUT))
      else $error("result raised outside output state");

   a_pipe_in_read: assert property (@(posedge clock) disable iff (reset)
      vld2_ff |-> (state_ff == tspm_pkg::ST_READ || state_ff == tspm_pkg::ST_DRAIN))
      else $error("accumulation outside voxel read");

   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.mul_start |-> !mul_busy)
      else $error("multiplier restarted while busy");

endmodule
